@@ sv/rma_pkg.sv @@
// ----------------------------------------------------------------------------
// rma_pkg
// Shared sizes, types and state codes for the ring moving average.
// ----------------------------------------------------------------------------
`default_nettype none

package rma_pkg;

    localparam int RING_DEPTH = 8;
    localparam int SAMPLE_W   = 32;
    localparam int POS_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int SUM_W      = SAMPLE_W + $clog2(RING_DEPTH);
    localparam int DIV_W      = SUM_W + 1;
    localparam int OUT_CNT_W  = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUB,
        ST_ADD,
        ST_START,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic clr;
        logic sub;
        logic add;
    } t_ring_ctl;

endpackage

`default_nettype wire

@@ sv/rma_divider.sv @@
// ----------------------------------------------------------------------------
// rma_divider
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rma_divider
    import rma_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [DIV_W-1:0]    i_dividend,
    input  wire logic [CNT_W-1:0]    i_divisor,
    output logic                     o_done,
    output logic [SAMPLE_W-1:0]      o_quotient
);

    localparam int BIT_W = $clog2(DIV_W + 1);

    logic [BIT_W-1:0] r_bits, n_bits;
    logic             r_done, n_done;
    logic [DIV_W-1:0] r_sh, n_sh;
    logic [CNT_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0] r_div, n_div;
    logic [CNT_W:0]   w_trial;
    logic             w_qbit;

    assign w_trial = {r_rem, r_sh[DIV_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_div});

    always_comb begin
        n_bits = r_bits;
        n_done = 1'b0;
        n_sh   = r_sh;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_sh   = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
            n_bits = BIT_W'(DIV_W);
        end else if (r_bits != '0) begin
            n_sh   = {r_sh[DIV_W-2:0], w_qbit};
            n_rem  = w_qbit ? CNT_W'(w_trial - {1'b0, r_div}) : w_trial[CNT_W-1:0];
            n_bits = r_bits - 1'b1;
            n_done = (r_bits == BIT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
            r_done <= 1'b0;
        end else begin
            r_bits <= n_bits;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sh  <= n_sh;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done     = r_done;
    assign o_quotient = r_sh[SAMPLE_W-1:0];

endmodule

`default_nettype wire

@@ sv/rma_ring.sv @@
// ----------------------------------------------------------------------------
// rma_ring
// Sample ring with write position, held count and running sum.
// ----------------------------------------------------------------------------
`default_nettype none

module rma_ring
    import rma_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_ring_ctl           i_ctl,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    output logic [SUM_W-1:0]         o_sum,
    output logic [CNT_W-1:0]         o_cnt
);

    logic [SAMPLE_W-1:0] r_ring [RING_DEPTH];
    logic [POS_W-1:0]    r_pos;
    logic [CNT_W-1:0]    r_cnt;
    logic [SUM_W-1:0]    r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            for (int i = 0; i < RING_DEPTH; i++) begin
                r_ring[i] <= '0;
            end
            r_pos <= '0;
            r_cnt <= '0;
            r_sum <= '0;
        end else if (i_ctl.sub) begin
            // drop the slot about to be overwritten (zero while not full)
            r_sum <= r_sum - SUM_W'(r_ring[r_pos]);
        end else if (i_ctl.add) begin
            r_sum         <= r_sum + SUM_W'(i_sample);
            r_ring[r_pos] <= i_sample;
            if (r_pos == POS_W'(RING_DEPTH - 1)) begin
                r_pos <= '0;
            end else begin
                r_pos <= r_pos + 1'b1;
            end
            if (r_cnt != CNT_W'(RING_DEPTH)) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_sum = r_sum;
    assign o_cnt = r_cnt;

endmodule

`default_nettype wire

@@ sv/ring_moving_average.sv @@
// ----------------------------------------------------------------------------
// ring_moving_average
// Boxcar moving average over the most recent nonzero samples, with clear.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                  | tuser
//  s       | in  | [31:0] sample_value                    | [0] action (1 = clear)
//  m       | out | [31:0] average_value, [35:32] stored_count | -
//
//  A nonzero sample's result passes the subtract, add, start, divide and output
//  states after its transfer; the divide state waits on the bit-serial divider
//  producing one quotient bit per cycle. A zero sample or a clear goes straight
//  to the output state. The next transfer is taken only once the result is in
//  the output register. One item is in work at a time.
//  Reset is synchronous; ring, count, sum and average clear at once.
//  A stalled result sits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_moving_average
    import rma_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [31:0]  i_s_tdata,   // [31:0] sample_value
    input  wire logic [0:0]   i_s_tuser,   // [0] action
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [39:0]       o_m_tdata    // [31:0] average_value, [35:32] stored_count
);

    t_state              r_state, n_state;
    t_ring_ctl           w_ctl;
    logic [SAMPLE_W-1:0] r_sample;
    logic [SAMPLE_W-1:0] r_avg, n_avg;
    logic                r_out_valid, n_out_valid;
    logic [SAMPLE_W-1:0] r_out_avg, n_out_avg;
    logic [OUT_CNT_W-1:0] r_out_cnt, n_out_cnt;
    logic                w_s_xfer;
    logic                w_div_start;
    logic                w_div_done;
    logic [SAMPLE_W-1:0] w_quotient;
    logic [SUM_W-1:0]    w_sum;
    logic [CNT_W-1:0]    w_cnt;
    logic [DIV_W-1:0]    w_dividend;

    assign w_s_xfer   = i_s_tvalid && o_s_tready;
    assign w_dividend = DIV_W'(w_sum) + DIV_W'(w_cnt >> 1);

    rma_ring u_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_sample (r_sample),
        .o_sum    (w_sum),
        .o_cnt    (w_cnt)
    );

    rma_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_cnt),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    always_comb begin
        n_state     = r_state;
        n_avg       = r_avg;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_avg   = r_out_avg;
        n_out_cnt   = r_out_cnt;
        w_ctl       = '0;
        w_div_start = 1'b0;
        o_s_tready  = (r_state == ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (w_s_xfer) begin
                    if (i_s_tuser[0]) begin
                        w_ctl.clr = 1'b1;
                        n_avg     = '0;
                        n_state   = ST_OUT;
                    end else if (i_s_tdata != '0) begin
                        n_state = ST_SUB;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_SUB: begin
                w_ctl.sub = 1'b1;
                n_state   = ST_ADD;
            end
            ST_ADD: begin
                w_ctl.add = 1'b1;
                n_state   = ST_START;
            end
            ST_START: begin
                w_div_start = 1'b1;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_avg   = w_quotient;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_avg   = r_avg;
                    n_out_cnt   = OUT_CNT_W'(w_cnt);
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_avg       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_avg       <= n_avg;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_avg <= n_out_avg;
        r_out_cnt <= n_out_cnt;
        if (w_s_xfer) begin
            r_sample <= i_s_tdata;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0, r_out_cnt, r_out_avg};

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_xfer && i_s_tuser[0]) |=> (w_cnt == '0 && r_avg == '0 && r_state == ST_OUT))
        else $error("clear did not empty the ring");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cnt <= CNT_W'(RING_DEPTH))
        else $error("held count above ring depth");

    a_out_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> ($past(r_state) == ST_OUT))
        else $error("result raised outside the output state");

endmodule

`default_nettype wire

@@ bench/ring_moving_average_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_moving_average_tb
// Streams samples and clears into the moving average and checks each result
// against a local running-ring predictor. Covers ring fill and wrap, rounding,
// ignored zero samples, clears, random traffic under three idle patterns, a
// long output stall and a drained pause.
// ----------------------------------------------------------------------------

module ring_moving_average_tb;

    import rma_pkg::*;

    localparam int  CLK_HALF    = 6;
    localparam int  CYCLE_LIMIT = 600000;
    localparam int  HOLD_CYCLES = 500;
    localparam int  TAIL_CYCLES = 60;
    localparam bit  ACT_SAMPLE  = 1'b0;
    localparam bit  ACT_CLEAR   = 1'b1;

    typedef struct packed {
        logic [3:0]  count;
        logic [31:0] average;
    } t_avg_result;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [31:0] i_s_tdata  = '0;    // [31:0] sample_value
    logic [0:0]  i_s_tuser  = '0;    // [0] action
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [39:0] o_m_tdata;          // [31:0] average_value, [35:32] stored_count

    // predictor state
    logic [31:0] ring_copy [RING_DEPTH];
    int          ring_pos;
    int          ring_held;
    logic [63:0] ring_sum;
    logic [31:0] ring_avg;

    t_avg_result pending_averages [$];

    int errors       = 0;
    int items_in     = 0;
    int results_seen = 0;
    int clears_sent  = 0;
    int cycle_count  = 0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_requests = 0;

    ring_moving_average u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_averages.size());
            $display("FAILURE");
            $finish;
        end
    end

    function automatic void clear_ring();
        for (int k = 0; k < RING_DEPTH; k++) ring_copy[k] = '0;
        ring_pos  = 0;
        ring_held = 0;
        ring_sum  = '0;
        ring_avg  = '0;
    endfunction

    function automatic t_avg_result predict_average(input logic action,
                                                    input logic [31:0] sample);
        t_avg_result r;
        logic [63:0] n;
        if (action == ACT_CLEAR) begin
            clear_ring();
        end else if (sample != 32'd0) begin
            ring_sum = ring_sum - {32'd0, ring_copy[ring_pos]} + {32'd0, sample};
            ring_copy[ring_pos] = sample;
            ring_pos = (ring_pos + 1 >= RING_DEPTH) ? 0 : ring_pos + 1;
            if (ring_held < RING_DEPTH) ring_held++;
            n = 64'(ring_held);
            ring_avg = 32'((ring_sum + n / 2) / n);
        end
        r.average = ring_avg;
        r.count   = 4'(ring_held);
        return r;
    endfunction

    // input transfers feed the predictor, output transfers are checked
    always @(posedge i_clk) begin : monitor
        t_avg_result got;
        t_avg_result want;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                pending_averages.push_back(predict_average(i_s_tuser[0], i_s_tdata));
                items_in++;
            end
            if (o_m_tvalid && i_m_tready) begin
                got = o_m_tdata[35:0];
                results_seen++;
                if (pending_averages.size() == 0) begin
                    $error("result with nothing pending: tdata %h", o_m_tdata);
                    errors++;
                end else begin
                    want = pending_averages.pop_front();
                    if (got.average !== want.average) begin
                        $error("average_value: expected %0d, actual %0d",
                               want.average, got.average);
                        errors++;
                    end
                    if (got.count !== want.count) begin
                        $error("stored_count: expected %0d, actual %0d",
                               want.count, got.count);
                        errors++;
                    end
                end
            end
        end
    end

    // receiver; a hold request forces a long run of tready low
    always @(negedge i_clk) begin : receiver
        static int hold_served = 0;
        static int hold_left   = 0;
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_item(input logic action, input logic [31:0] sample);
        int gap;
        @(negedge i_clk);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            gap = $urandom_range(1, 45);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid   <= 1'b1;
        i_s_tdata    <= sample;
        i_s_tuser[0] <= action;
        if (action == ACT_CLEAR) clears_sent++;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic idle_bus();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_averages.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] random_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) return 32'd0;
        if (pick < 40) return 32'($urandom_range(1, 255));
        if (pick < 55) return 32'hFFFF_FF00 | 32'($urandom_range(0, 255));
        return $urandom();
    endfunction

    task automatic test_directed();
        tx_idle_pct = 21;
        rx_idle_pct = 72;
        send_item(ACT_CLEAR, 32'd0);
        send_item(ACT_SAMPLE, 32'd0);                  // zero sample on empty ring
        send_item(ACT_SAMPLE, 32'd1);
        send_item(ACT_SAMPLE, 32'd2);                  // (3 + 1) / 2 rounds up
        send_item(ACT_SAMPLE, 32'd2);
        send_item(ACT_SAMPLE, 32'd0);                  // ignored mid-fill
        send_item(ACT_CLEAR, 32'hFFFF_FFFF);           // sample field ignored on clear
        for (int k = 0; k < RING_DEPTH + 2; k++)
            send_item(ACT_SAMPLE, 32'hFFFF_FFFF);      // fill, saturate and wrap at max
        send_item(ACT_SAMPLE, 32'd0);                  // ignored on full ring
        send_item(ACT_SAMPLE, 32'h8000_0000);
        send_item(ACT_SAMPLE, 32'h7FFF_FFFF);
        send_item(ACT_SAMPLE, 32'h5555_5555);
        send_item(ACT_SAMPLE, 32'hAAAA_AAAA);
        send_item(ACT_CLEAR, 32'h1234_5678);
        send_item(ACT_SAMPLE, 32'd3);
        idle_bus();
        wait_drained();
    endtask

    task automatic test_random_phase(input int tx_pct, input int rx_pct, input int target);
        int counted;
        logic [31:0] s;
        counted = 0;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        while (counted < target) begin
            if ($urandom_range(99) < 4) begin
                send_item(ACT_CLEAR, $urandom());
            end else begin
                s = random_sample();
                send_item(ACT_SAMPLE, s);
            end
            counted++;
        end
    endtask

    task automatic test_output_stall();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_requests++;
        for (int k = 0; k < 12; k++)
            send_item(ACT_SAMPLE, 32'($urandom_range(1, 1000)));
        idle_bus();
        wait_drained();
    endtask

    task automatic test_sender_pause();
        tx_idle_pct = 0;
        rx_idle_pct = 30;
        for (int k = 0; k < 5; k++) send_item(ACT_SAMPLE, $urandom() | 32'd1);
        idle_bus();
        wait_drained();
        send_item(ACT_SAMPLE, 32'd0);
        for (int k = 0; k < 5; k++) send_item(ACT_SAMPLE, $urandom() | 32'd1);
        idle_bus();
        wait_drained();
    endtask

    initial begin
        clear_ring();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_phase(21, 72, 300);
        test_random_phase(72, 21, 300);
        test_random_phase(0, 0, 300);
        test_output_stall();
        test_sender_pause();

        idle_bus();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_averages.size() != 0) begin
            $error("%0d expected results never arrived", pending_averages.size());
            errors++;
        end

        $display("Run: %0d transfers in, %0d results checked, %0d clears, %0d errors.",
                 items_in, results_seen, clears_sent, errors);
        $display("Ring fill/wrap at max values, rounding, zero and clear items,");
        $display("three idle mixes, a long output stall and a drained pause.");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
